[rtl/kmpc_pkg.sv]
// shared types and constants for the k-means pixel clusterer
// no dependencies
`timescale 1ns / 1ps

package kmpc_pkg;

  localparam int COLOR_NORM = 195075;

  localparam int SNORM_W = 25;
  localparam int COEF_A_W = 34;
  localparam int COEF_A_LO = 17;
  localparam int COEF_B_W = 26;
  localparam int CSQ_W = 18;

  localparam logic [5:0] ACTIVE_RST = 6'd20;
  localparam logic [8:0] WEIGHT_RST = 9'd128;
  localparam logic [11:0] WIDTH_RST = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;
  localparam logic [8:0] WEIGHT_ONE = 9'd256;

  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_EOF = 2'd1,
    ACT_LOAD = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_ACTIVE = 2'd0,
    REG_WEIGHT = 2'd1,
    REG_WIDTH = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_OUT = 4'b0100,
    ST_DIV = 4'b1000
  } state_t;

  typedef struct packed {
    logic acc_en;
    logic ld_en;
    logic div_start;
  } ctrl_t;

endpackage

[rtl/kmpc_cell.sv]
// one center cell: center, sums, distance pipe, compare link and serial divider
// depends on kmpc_pkg
`timescale 1ns / 1ps

module kmpc_cell #(
  parameter int IDX = 0,
  parameter int CB = 11,
  parameter int PCB = 22,
  parameter int IW = 6,
  parameter int NW = 6,
  parameter int DDW = 53
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kmpc_pkg::ctrl_t               ctrl,
  input  logic [IW-1:0]                 acc_idx,
  input  logic [5:0]                    ld_idx,
  input  logic [NW-1:0]                 n_act,
  input  logic [CB-1:0]                 px,
  input  logic [CB-1:0]                 py,
  input  logic [7:0]                    pr,
  input  logic [7:0]                    pg,
  input  logic [7:0]                    pb,
  input  logic [kmpc_pkg::COEF_A_W-1:0] coef_a,
  input  logic [kmpc_pkg::COEF_B_W-1:0] coef_b,
  input  logic                          vin,
  input  logic [DDW-1:0]                din,
  input  logic [IW-1:0]                 iin,
  input  logic [23:0]                   cin,
  output logic                          vout,
  output logic [DDW-1:0]                dout,
  output logic [IW-1:0]                 iout,
  output logic [23:0]                   cout,
  output logic                          busy
);

  localparam int SCW = CB + PCB;
  localparam int SVW = 8 + PCB;
  localparam int DW = ((CB > 8) ? CB : 8) + PCB;
  localparam int CW = PCB + 1;
  localparam int BCW = $clog2(DW);
  localparam int SSW = 2 * CB + 1;
  localparam int PW = kmpc_pkg::CSQ_W + kmpc_pkg::COEF_A_LO;
  localparam int PSW = SSW + kmpc_pkg::COEF_B_W;

  logic [CB-1:0] col_r, row_r;
  logic [7:0] red_r, green_r, blue_r;
  logic [SCW-1:0] scol_r, srow_r;
  logic [SVW-1:0] sred_r, sgreen_r, sblue_r;
  logic [CW-1:0] cnt_r;

  logic [kmpc_pkg::CSQ_W-1:0] csq_r;
  logic [SSW-1:0] ssq_r;
  logic [PW-1:0] plo_r, phi_r;
  logic [PSW-1:0] ps_r;
  logic [DDW-1:0] d_r;

  logic vout_r;
  logic [DDW-1:0] dout_r;
  logic [IW-1:0] iout_r;
  logic [23:0] cout_r;

  logic busy_r, upd_r;
  logic [2:0] sel_r;
  logic [BCW-1:0] bcnt_r;
  logic [DW-1:0] dvd_r, quo_r;
  logic [CW-1:0] rem_r;

  logic act, take, hit, ld_hit, last;
  logic [7:0] dr, dg, db;
  logic [15:0] sqr, sqg, sqb;
  logic [CB-1:0] dx, dy;
  logic [2*CB-1:0] sqx, sqy;
  logic [kmpc_pkg::CSQ_W-1:0] csq_nxt;
  logic [SSW-1:0] ssq_nxt;
  logic [PW-1:0] plo_nxt, phi_nxt;
  logic [PSW-1:0] ps_nxt;
  logic [CW:0] trial;
  logic ge;
  logic [CW-1:0] rem_nxt;
  logic [DW-1:0] q_nxt, next_sum;

  assign act = NW'(IDX) < n_act;

  always_comb begin
    dr = (pr >= red_r) ? pr - red_r : red_r - pr;
    dg = (pg >= green_r) ? pg - green_r : green_r - pg;
    db = (pb >= blue_r) ? pb - blue_r : blue_r - pb;
    dx = (px >= col_r) ? px - col_r : col_r - px;
    dy = (py >= row_r) ? py - row_r : row_r - py;
    sqr = dr * dr;
    sqg = dg * dg;
    sqb = db * db;
    sqx = dx * dx;
    sqy = dy * dy;
    csq_nxt = kmpc_pkg::CSQ_W'(sqr) + kmpc_pkg::CSQ_W'(sqg) + kmpc_pkg::CSQ_W'(sqb);
    ssq_nxt = SSW'(sqx) + SSW'(sqy);
    plo_nxt = csq_r * coef_a[kmpc_pkg::COEF_A_LO-1:0];
    phi_nxt = csq_r * coef_a[kmpc_pkg::COEF_A_W-1:kmpc_pkg::COEF_A_LO];
    ps_nxt = ssq_r * coef_b;
  end

  always_ff @(posedge clk) begin
    csq_r <= csq_nxt;
    ssq_r <= ssq_nxt;
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
    ps_r <= ps_nxt;
    d_r <= (DDW'(phi_r) << kmpc_pkg::COEF_A_LO) + DDW'(plo_r) + DDW'(ps_r);
  end

  // compare link, lower index wins ties
  assign take = !vin || (act && (d_r < din));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else begin
      vout_r <= 1'b1;
    end
    dout_r <= take ? d_r : din;
    iout_r <= take ? IW'(IDX) : iin;
    cout_r <= take ? {red_r, green_r, blue_r} : cin;
  end

  assign vout = vout_r;
  assign dout = dout_r;
  assign iout = iout_r;
  assign cout = cout_r;
  assign busy = busy_r;

  // restoring divider, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, dvd_r[DW-1]};
    ge = trial >= {1'b0, cnt_r};
    rem_nxt = ge ? CW'(trial - {1'b0, cnt_r}) : CW'(trial);
    q_nxt = {quo_r[DW-2:0], ge};
    last = bcnt_r == BCW'(DW - 1);
    unique case (sel_r)
      3'd0: next_sum = DW'(srow_r);
      3'd1: next_sum = DW'(sred_r);
      3'd2: next_sum = DW'(sgreen_r);
      3'd3: next_sum = DW'(sblue_r);
      default: next_sum = DW'(scol_r);
    endcase
  end

  assign hit = ctrl.acc_en && (acc_idx == IW'(IDX)) && !cnt_r[PCB];
  assign ld_hit = ctrl.ld_en && (ld_idx == 6'(IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sel_r <= 3'd0;
      bcnt_r <= '0;
      upd_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
      red_r <= '0;
      green_r <= '0;
      blue_r <= '0;
      scol_r <= '0;
      srow_r <= '0;
      sred_r <= '0;
      sgreen_r <= '0;
      sblue_r <= '0;
      cnt_r <= '0;
    end else begin
      if (ld_hit) begin
        col_r <= px;
        row_r <= py;
        red_r <= pr;
        green_r <= pg;
        blue_r <= pb;
      end
      if (hit) begin
        scol_r <= scol_r + SCW'(px);
        srow_r <= srow_r + SCW'(py);
        sred_r <= sred_r + SVW'(pr);
        sgreen_r <= sgreen_r + SVW'(pg);
        sblue_r <= sblue_r + SVW'(pb);
        cnt_r <= cnt_r + CW'(1);
      end
      if (ctrl.div_start) begin
        busy_r <= 1'b1;
        sel_r <= 3'd0;
        bcnt_r <= '0;
        dvd_r <= DW'(scol_r);
        rem_r <= '0;
        upd_r <= act && (cnt_r != '0);
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= q_nxt;
        dvd_r <= {dvd_r[DW-2:0], 1'b0};
        bcnt_r <= bcnt_r + BCW'(1);
        if (last) begin
          if (upd_r) begin
            unique case (sel_r)
              3'd0: col_r <= q_nxt[CB-1:0];
              3'd1: row_r <= q_nxt[CB-1:0];
              3'd2: red_r <= q_nxt[7:0];
              3'd3: green_r <= q_nxt[7:0];
              default: blue_r <= q_nxt[7:0];
            endcase
          end
          bcnt_r <= '0;
          rem_r <= '0;
          dvd_r <= next_sum;
          if (sel_r == 3'd4) begin
            busy_r <= 1'b0;
            scol_r <= '0;
            srow_r <= '0;
            sred_r <= '0;
            sgreen_r <= '0;
            sblue_r <= '0;
            cnt_r <= '0;
          end else begin
            sel_r <= sel_r + 3'd1;
          end
        end
      end
    end
  end

endmodule

[rtl/kmeans_pixel_clusterer.sv]
// top level: config registers, sequencer, output register and the chain of center cells
// depends on kmpc_pkg and kmpc_cell
`timescale 1ns / 1ps

// A pixel transaction, once accepted, runs through the distance pipeline inside every cell
// (squared differences, weighted products, summed distance); then the best-so-far value
// walks the chain of center cells one cell per cycle to the output register. An end-of-frame
// transaction holds the input while the serial divider in each cell produces one quotient
// bit per cycle for each of the five sums in turn; all cells divide in parallel. A load
// transaction writes the seed into its cell from the idle state. One transaction is worked
// on at a time; a finished result waits in the output register while the next is taken.

module kmeans_pixel_clusterer #(
  parameter int MAX_CLUSTERS = 40,
  parameter int COORD_BITS = 11,
  parameter int PIXEL_COUNT_BITS = 22
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_alpha,
  input  logic [5:0]            in_seed_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic [5:0]            out_chosen_cluster,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [3:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int NW = $clog2(MAX_CLUSTERS + 1);
  localparam int DDW = (((2 * COORD_BITS + 27) > 52) ? (2 * COORD_BITS + 27) : 52) + 1;
  localparam int LAT = MAX_CLUSTERS + 5;
  localparam int LCW = $clog2(LAT + 1);

  kmpc_pkg::state_t state_r, state_nxt;
  logic [LCW-1:0] cnt_r;

  logic [5:0] act_r;
  logic [8:0] sw_r;
  logic [11:0] fw_r, fh_r;

  logic [kmpc_pkg::SNORM_W-1:0] snorm_r, snorm_nxt;
  logic [kmpc_pkg::COEF_A_W-1:0] coef_a_r;
  logic [kmpc_pkg::COEF_B_W-1:0] coef_b_r;
  logic [8:0] wsat;
  logic [6:0] n_wide;
  logic [NW-1:0] n_act;

  logic [COORD_BITS-1:0] px_r, py_r;
  logic [7:0] pr_r, pg_r, pb_r, pa_r;
  logic [5:0] seed_r;
  logic ld_en_r;

  logic out_valid_r;
  logic [7:0] ored_r, ogreen_r, oblue_r, oalpha_r;
  logic [5:0] oidx_r;

  logic accept, cfg_wr, out_free;
  kmpc_pkg::ctrl_t ctrl;

  logic v_w [0:MAX_CLUSTERS];
  logic [DDW-1:0] d_w [0:MAX_CLUSTERS];
  logic [IW-1:0] i_w [0:MAX_CLUSTERS];
  logic [23:0] c_w [0:MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] div_busy;

  assign accept = in_valid && in_ready;
  assign in_ready = state_r == kmpc_pkg::ST_IDLE;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign out_free = !out_valid_r || out_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= kmpc_pkg::ACTIVE_RST;
      sw_r <= kmpc_pkg::WEIGHT_RST;
      fw_r <= kmpc_pkg::WIDTH_RST;
      fh_r <= kmpc_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (kmpc_pkg::reg_idx_t'(cfg_paddr[3:2]))
        kmpc_pkg::REG_ACTIVE: act_r <= cfg_pwdata[5:0];
        kmpc_pkg::REG_WEIGHT: sw_r <= cfg_pwdata[8:0];
        kmpc_pkg::REG_WIDTH: fw_r <= cfg_pwdata[11:0];
        kmpc_pkg::REG_HEIGHT: fh_r <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (kmpc_pkg::reg_idx_t'(cfg_paddr[3:2]))
      kmpc_pkg::REG_ACTIVE: cfg_prdata = 32'(act_r);
      kmpc_pkg::REG_WEIGHT: cfg_prdata = 32'(sw_r);
      kmpc_pkg::REG_WIDTH: cfg_prdata = 32'(fw_r);
      kmpc_pkg::REG_HEIGHT: cfg_prdata = 32'(fh_r);
      default: cfg_prdata = '0;
    endcase
  end

  // per-frame distance coefficients
  always_comb begin
    snorm_nxt = fw_r * fw_r + fh_r * fh_r;
    if (snorm_nxt == '0) begin
      snorm_nxt = kmpc_pkg::SNORM_W'(1);
    end
    wsat = (sw_r > kmpc_pkg::WEIGHT_ONE) ? kmpc_pkg::WEIGHT_ONE : sw_r;
    n_wide = (7'(act_r) > 7'(MAX_CLUSTERS)) ? 7'(MAX_CLUSTERS) : 7'(act_r);
    n_act = NW'(n_wide);
  end

  always_ff @(posedge clk) begin
    snorm_r <= snorm_nxt;
    coef_a_r <= (kmpc_pkg::WEIGHT_ONE - wsat) * snorm_r;
    coef_b_r <= wsat * kmpc_pkg::COEF_B_W'(kmpc_pkg::COLOR_NORM);
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      pr_r <= in_red;
      pg_r <= in_green;
      pb_r <= in_blue;
      pa_r <= in_alpha;
      seed_r <= in_seed_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_en_r <= 1'b0;
    end else begin
      ld_en_r <= accept && (in_action == kmpc_pkg::ACT_LOAD) &&
                 (7'(in_seed_index) < 7'(MAX_CLUSTERS));
    end
  end

  assign ctrl.acc_en = (state_r == kmpc_pkg::ST_OUT) && out_free;
  assign ctrl.ld_en = ld_en_r;
  assign ctrl.div_start = accept && (in_action == kmpc_pkg::ACT_EOF);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kmpc_pkg::ST_IDLE: begin
        if (accept && in_action == kmpc_pkg::ACT_PIXEL) begin
          state_nxt = kmpc_pkg::ST_CALC;
        end else if (accept && in_action == kmpc_pkg::ACT_EOF) begin
          state_nxt = kmpc_pkg::ST_DIV;
        end
      end
      kmpc_pkg::ST_CALC: begin
        if (cnt_r == LCW'(LAT)) begin
          state_nxt = kmpc_pkg::ST_OUT;
        end
      end
      kmpc_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = kmpc_pkg::ST_IDLE;
        end
      end
      kmpc_pkg::ST_DIV: begin
        if (!(|div_busy)) begin
          state_nxt = kmpc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kmpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kmpc_pkg::ST_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == kmpc_pkg::ST_CALC) begin
        cnt_r <= cnt_r + LCW'(1);
      end else begin
        cnt_r <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.acc_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctrl.acc_en) begin
      ored_r <= c_w[MAX_CLUSTERS][23:16];
      ogreen_r <= c_w[MAX_CLUSTERS][15:8];
      oblue_r <= c_w[MAX_CLUSTERS][7:0];
      oalpha_r <= pa_r;
      oidx_r <= 6'(i_w[MAX_CLUSTERS]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_red = ored_r;
  assign out_green = ogreen_r;
  assign out_blue = oblue_r;
  assign out_alpha = oalpha_r;
  assign out_chosen_cluster = oidx_r;

  // chain of center cells
  assign v_w[0] = 1'b0;
  assign d_w[0] = '0;
  assign i_w[0] = '0;
  assign c_w[0] = '0;

  for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
    kmpc_cell #(
      .IDX(k),
      .CB(COORD_BITS),
      .PCB(PIXEL_COUNT_BITS),
      .IW(IW),
      .NW(NW),
      .DDW(DDW)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .ctrl(ctrl),
      .acc_idx(i_w[MAX_CLUSTERS]),
      .ld_idx(seed_r),
      .n_act(n_act),
      .px(px_r),
      .py(py_r),
      .pr(pr_r),
      .pg(pg_r),
      .pb(pb_r),
      .coef_a(coef_a_r),
      .coef_b(coef_b_r),
      .vin(v_w[k]),
      .din(d_w[k]),
      .iin(i_w[k]),
      .cin(c_w[k]),
      .vout(v_w[k+1]),
      .dout(d_w[k+1]),
      .iout(i_w[k+1]),
      .cout(c_w[k+1]),
      .busy(div_busy[k])
    );
  end

  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (|div_busy) |-> !in_ready)
    else $error("input taken while centers update");

  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.acc_en |=> out_valid_r)
    else $error("accumulation without a result");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (7'(oidx_r) < 7'(MAX_CLUSTERS)))
    else $error("chosen cluster out of range");

  a_busy_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    ((|div_busy) |-> (&div_busy)))
    else $error("cell dividers out of step");

endmodule

[test/kmeans_pixel_clusterer_tb.sv]
// self-checking testbench for the k-means pixel clusterer: seeds, pixels, end of frame, config
// depends on kmpc_pkg and the kmeans_pixel_clusterer rtl
`timescale 1ns / 1ps

module kmeans_pixel_clusterer_tb;

  localparam int NCLUST = 40;
  localparam int COUNT_CAP = 1 << 22;
  localparam int EOF_CYCLES = 5 * (11 + 22) + 2;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [5:0] cluster;
  } color_out_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_action;
  logic [10:0] in_pos_x, in_pos_y;
  logic [7:0] in_red, in_green, in_blue, in_alpha;
  logic [5:0] in_seed_index;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic [5:0] out_chosen_cluster;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  // predictor state
  logic [5:0] m_active;
  logic [8:0] m_weight;
  logic [11:0] m_width, m_height;
  logic [10:0] ctr_col [NCLUST];
  logic [10:0] ctr_row [NCLUST];
  logic [7:0] ctr_red [NCLUST];
  logic [7:0] ctr_green [NCLUST];
  logic [7:0] ctr_blue [NCLUST];
  longint unsigned acc_col [NCLUST];
  longint unsigned acc_row [NCLUST];
  longint unsigned acc_red [NCLUST];
  longint unsigned acc_green [NCLUST];
  longint unsigned acc_blue [NCLUST];
  int unsigned members [NCLUST];

  color_out_t pending_colors[$];
  int errors;
  int n_pixels, n_frames, n_loads, n_results;
  int stall_req;

  kmeans_pixel_clusterer dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // result checker and receiver stalls
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_colors.size() == 0) begin
        report("unexpected result", out_chosen_cluster, -1);
      end else begin
        color_out_t e;
        e = pending_colors.pop_front();
        if (out_red !== e.red) report("out_red", out_red, e.red);
        if (out_green !== e.green) report("out_green", out_green, e.green);
        if (out_blue !== e.blue) report("out_blue", out_blue, e.blue);
        if (out_alpha !== e.alpha) report("out_alpha", out_alpha, e.alpha);
        if (out_chosen_cluster !== e.cluster)
          report("out_chosen_cluster", out_chosen_cluster, e.cluster);
      end
    end
    if (stall_req > 0) begin
      hold_left = stall_req;
      stall_req = 0;
    end else if (hold_left == 0 && $urandom_range(0, 399) == 0) begin
      hold_left = $urandom_range(40, 150);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7);
    end
  end

  task automatic clear_accums();
    for (int k = 0; k < NCLUST; k++) begin
      acc_col[k] = 0; acc_row[k] = 0; acc_red[k] = 0;
      acc_green[k] = 0; acc_blue[k] = 0; members[k] = 0;
    end
  endtask

  function automatic longint unsigned sqd(input int a, input int b);
    longint unsigned d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  task automatic predict(input logic [1:0] act, input logic [10:0] px, input logic [10:0] py,
                         input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                         input logic [7:0] a, input logic [5:0] seed);
    int n;
    int best;
    longint unsigned w, snorm, csq, ssq, d, best_d;
    color_out_t e;
    n = (m_active > NCLUST) ? NCLUST : m_active;
    case (act)
      kmpc_pkg::ACT_PIXEL: begin
        w = (m_weight > kmpc_pkg::WEIGHT_ONE) ? 256 : m_weight;
        snorm = longint'(m_width) * m_width + longint'(m_height) * m_height;
        if (snorm == 0) snorm = 1;
        best = 0;
        best_d = 0;
        for (int k = 0; k < n; k++) begin
          csq = sqd(r, ctr_red[k]) + sqd(g, ctr_green[k]) + sqd(b, ctr_blue[k]);
          ssq = sqd(px, ctr_col[k]) + sqd(py, ctr_row[k]);
          d = (256 - w) * csq * snorm + w * ssq * kmpc_pkg::COLOR_NORM;
          if (k == 0 || d < best_d) begin
            best_d = d;
            best = k;
          end
        end
        if (members[best] < COUNT_CAP) begin
          acc_col[best] += px; acc_row[best] += py; acc_red[best] += r;
          acc_green[best] += g; acc_blue[best] += b; members[best]++;
        end
        e.red = ctr_red[best];
        e.green = ctr_green[best];
        e.blue = ctr_blue[best];
        e.alpha = a;
        e.cluster = 6'(best);
        pending_colors.push_back(e);
        n_pixels++;
      end
      kmpc_pkg::ACT_EOF: begin
        for (int k = 0; k < n; k++) begin
          if (members[k] > 0) begin
            ctr_col[k] = 11'(acc_col[k] / members[k]);
            ctr_row[k] = 11'(acc_row[k] / members[k]);
            ctr_red[k] = 8'(acc_red[k] / members[k]);
            ctr_green[k] = 8'(acc_green[k] / members[k]);
            ctr_blue[k] = 8'(acc_blue[k] / members[k]);
          end
        end
        clear_accums();
        n_frames++;
      end
      kmpc_pkg::ACT_LOAD: begin
        if (seed < NCLUST) begin
          ctr_col[seed] = px; ctr_row[seed] = py; ctr_red[seed] = r;
          ctr_green[seed] = g; ctr_blue[seed] = b;
        end
        n_loads++;
      end
      default: ;
    endcase
  endtask

  // one transaction on the input channel, preceded by a random gap when gaps is set
  task automatic send_item(input logic [1:0] act, input logic [10:0] px, input logic [10:0] py,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [7:0] a, input logic [5:0] seed, input bit gaps = 1);
    int p, gap;
    p = $urandom_range(0, 99);
    gap = !gaps ? 0 : (p < 60) ? 0 : (p < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_pos_x <= px; in_pos_y <= py;
    in_red <= r; in_green <= g; in_blue <= b;
    in_alpha <= a; in_seed_index <= seed;
    do @(posedge clk); while (!in_ready);
    predict(act, px, py, r, g, b, a, seed);
  endtask

  task automatic send_pixel(input bit gaps = 1);
    send_item(kmpc_pkg::ACT_PIXEL, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, gaps);
  endtask

  task automatic send_seed(input int idx);
    send_item(kmpc_pkg::ACT_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              6'(idx));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (EOF_CYCLES + 20) @(posedge clk);
  endtask

  // register write, only once the block has nothing in flight
  task automatic cfg_write(input kmpc_pkg::reg_idx_t idx, input logic [31:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (!in_ready || pending_colors.size() != 0) @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      kmpc_pkg::REG_ACTIVE: m_active = val[5:0];
      kmpc_pkg::REG_WEIGHT: m_weight = val[8:0];
      kmpc_pkg::REG_WIDTH: m_width = val[11:0];
      default: m_height = val[11:0];
    endcase
  endtask

  task automatic set_config(input int act, input int wt, input int wd, input int ht);
    cfg_write(kmpc_pkg::REG_ACTIVE, act);
    cfg_write(kmpc_pkg::REG_WEIGHT, wt);
    cfg_write(kmpc_pkg::REG_WIDTH, wd);
    cfg_write(kmpc_pkg::REG_HEIGHT, ht);
  endtask

  task automatic test_reset_defaults();
    send_item(kmpc_pkg::ACT_PIXEL, 0, 0, 0, 0, 0, 0, 0);
    send_item(kmpc_pkg::ACT_PIXEL, 11'h7ff, 11'h7ff, 8'hff, 8'hff, 8'hff, 8'hff, 6'h3f);
    send_item(kmpc_pkg::ACT_NONE, 11'h7ff, 11'h7ff, 8'hff, 8'hff, 8'hff, 8'hff, 6'h3f);
    send_item(kmpc_pkg::ACT_EOF, 0, 0, 0, 0, 0, 0, 0);
    send_pixel();
    drain();
  endtask

  task automatic test_seeds_and_extremes();
    set_config(NCLUST, 256, 2048, 2048);
    for (int k = 0; k < 8; k++) send_seed(k * 5);
    send_seed(NCLUST);
    send_seed(63);
    send_item(kmpc_pkg::ACT_LOAD, 11'h7ff, 0, 8'hff, 0, 8'hff, 0, NCLUST - 1);
    send_item(kmpc_pkg::ACT_PIXEL, 11'h7ff, 0, 8'hff, 0, 8'hff, 8'h55, 0);
    send_item(kmpc_pkg::ACT_PIXEL, 0, 11'h7ff, 0, 8'hff, 0, 8'haa, 0);
    cfg_write(kmpc_pkg::REG_WEIGHT, 0);
    send_item(kmpc_pkg::ACT_PIXEL, 11'h555, 11'h2aa, 8'h55, 8'haa, 8'h0f, 8'hf0, 0);
    send_item(kmpc_pkg::ACT_EOF, 0, 0, 0, 0, 0, 0, 0);
    send_pixel();
    drain();
  endtask

  task automatic test_zero_active();
    set_config(0, 128, 640, 480);
    repeat (6) send_pixel();
    send_item(kmpc_pkg::ACT_EOF, 0, 0, 0, 0, 0, 0, 0);
    send_pixel();
    drain();
  endtask

  task automatic test_saturation();
    set_config(63, 511, 0, 0);
    for (int k = 0; k < NCLUST; k++) send_seed(k);
    repeat (10) send_pixel();
    drain();
    set_config(41, 300, 4095, 1);
    repeat (10) send_pixel();
    send_item(kmpc_pkg::ACT_EOF, 0, 0, 0, 0, 0, 0, 0);
    repeat (5) send_pixel();
    drain();
  endtask

  // frames of seeds, pixels, occasional no-action items and end of frame under several settings
  task automatic test_random_frames(input int n_items);
    int target;
    target = n_pixels + n_items;
    while (n_pixels < target) begin
      case ($urandom_range(0, 3))
        0: set_config($urandom_range(0, 63), $urandom_range(0, 511),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
        1: set_config(NCLUST, 256, 1, 1);
        2: set_config(1, 0, 2048, 2048);
        default: set_config($urandom_range(2, 12), $urandom_range(0, 256),
                            $urandom_range(1, 2048), $urandom_range(1, 2048));
      endcase
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 6)) send_seed($urandom_range(0, 63));
        repeat ($urandom_range(20, 90)) begin
          if ($urandom_range(0, 49) == 0)
            send_item(kmpc_pkg::ACT_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
          send_pixel();
        end
        send_item(kmpc_pkg::ACT_EOF, 0, 0, 0, 0, 0, 0, 0);
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    set_config(NCLUST, 128, 640, 480);
    stall_req = 500;
    repeat (60) send_pixel(0);
    drain();
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_action = kmpc_pkg::ACT_NONE;
    in_pos_x = 0; in_pos_y = 0; in_red = 0; in_green = 0; in_blue = 0;
    in_alpha = 0; in_seed_index = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    errors = 0; n_pixels = 0; n_frames = 0; n_loads = 0; n_results = 0;
    stall_req = 0;
    m_active = kmpc_pkg::ACTIVE_RST; m_weight = kmpc_pkg::WEIGHT_RST;
    m_width = kmpc_pkg::WIDTH_RST; m_height = kmpc_pkg::HEIGHT_RST;
    for (int k = 0; k < NCLUST; k++) begin
      ctr_col[k] = 0; ctr_row[k] = 0; ctr_red[k] = 0; ctr_green[k] = 0; ctr_blue[k] = 0;
    end
    clear_accums();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_seeds_and_extremes();
    test_zero_active();
    test_saturation();
    test_backpressure();
    test_random_frames(1250);
    $display("covered %0d pixels, %0d frame updates, %0d seed loads, %0d results checked",
             n_pixels, n_frames, n_loads, n_results);
    $display("configs included zero and saturated cluster counts, weights and frame sizes");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
